[design/fuzzy_word_match_scorer_top_defines.svh]
// Assertion macros shared by the checker of the match scorer.
// No dependencies.
`ifndef FUZZY_WORD_MATCH_SCORER_TOP_DEFINES_SVH
`define FUZZY_WORD_MATCH_SCORER_TOP_DEFINES_SVH
// check a property on every clock edge outside reset
`define FWMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check a property with reset applied as well
`define FWMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[design/fwms_pkg.sv]
// Types and constants shared by the fuzzy word match scorer.
// No dependencies.
package fwms_pkg;
    localparam int unsigned PAT_BYTES = 8;
    localparam int unsigned PLEN_W = 4;
    localparam int unsigned SCORE_W = 16;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [1:0] REG_PATTERN = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_TERMINUS = 2'd2;

    // word summary handed from the front to the back
    typedef struct packed {
        logic        zero;      // score forced to zero
        logic        overlong;
        logic [4:0]  best;      // numerator in halves of 1/L
        logic        dbl;       // terminus doubling
        logic [15:0] len;       // word length
    } summ_t;

    function automatic logic [7:0] fold(input logic [7:0] b);
        fold = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    function automatic logic is_upper(input logic [7:0] b);
        is_upper = (b >= 8'h41 && b <= 8'h5A);
    endfunction
endpackage

[design/fwms_front.sv]
// Front part: per-byte matching state, emits one summary per word.
// Depends on fwms_pkg.
module fwms_front
    import fwms_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = 8,
    parameter int unsigned MAX_WORD_LEN = 255,
    parameter int unsigned CNT_W = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [8*PAT_BYTES-1:0] pattern_bytes,
    input  logic [PLEN_W-1:0]      pattern_length,
    input  logic                   tail_mode,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             word_byte,
    input  logic                   word_end,
    output logic                   sum_valid,
    input  logic                   sum_ready,
    output summ_t                  sum_data
);
    localparam logic [PLEN_W-1:0] MAXP = PLEN_W'(MAX_PATTERN);
    localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_WORD_LEN);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        prev_reg;
    logic              skip_reg, skip_next;
    logic [1:0]        bcnt_reg, bcnt_next;
    logic [PLEN_W-1:0] bpos_reg, bpos_next;
    logic              bfail_reg, bfail_next;
    logic [PLEN_W-1:0] spos_reg, spos_next;
    logic              pfx_reg, pfx_next;
    logic [PLEN_W-1:0] cpos_reg, cpos_next;
    logic [1:0]        clev_reg, clev_next;
    logic [4:0]        chalf_reg, chalf_next;
    logic              ovf_reg, ovf_next;
    logic              sv_reg;
    summ_t             sd_reg, sd_next;

    logic [PLEN_W-1:0] plen;
    logic [7:0]        fb;
    logic              push, bhit, acc;
    logic [PLEN_W-1:0] bfound;
    logic [7:0]        pat [PAT_BYTES];
    logic [15:0]       len16;
    logic [4:0]        best;
    logic [1:0]        acnt;

    assign plen = (pattern_length > MAXP) ? MAXP : pattern_length;
    assign fb = fold(word_byte);
    assign in_ready = !sv_reg || sum_ready;
    assign acc = in_valid && in_ready;
    assign sum_valid = sv_reg;
    assign sum_data = sd_reg;

    always_comb
    begin
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            pat[k] = pattern_bytes[8*k +: 8];
        end
    end

    // first pattern byte at or after bpos that matches, in parallel compares
    always_comb
    begin
        bhit = 1'b0;
        bfound = '0;
        for (int k = PAT_BYTES - 1; k >= 0; k--)
        begin
            if (PLEN_W'(k) >= bpos_reg && PLEN_W'(k) < plen && fold(pat[k]) == fb)
            begin
                bhit = 1'b1;
                bfound = PLEN_W'(k);
            end
        end
    end

    always_comb
    begin
        push = 1'b0;
        skip_next = skip_reg;
        if (cnt_reg == '0)
        begin
            push = 1'b1;
        end
        else if (cnt_reg >= CNT_W'(2))
        begin
            if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else if (prev_reg == CH_UNDER || prev_reg == CH_DASH ||
                     (!is_upper(prev_reg) && is_upper(word_byte)))
            begin
                push = 1'b1;
                skip_next = 1'b1;
            end
        end
        bcnt_next = bcnt_reg;
        bpos_next = bpos_reg;
        bfail_next = bfail_reg;
        if (push)
        begin
            if (bcnt_reg < 2'd2)
            begin
                bcnt_next = bcnt_reg + 2'd1;
            end
            if (!bfail_reg)
            begin
                if (bhit)
                begin
                    bpos_next = bfound + PLEN_W'(1);
                end
                else
                begin
                    bfail_next = 1'b1;
                end
            end
        end
        spos_next = spos_reg;
        if (spos_reg < plen && fb == fold(pat[spos_reg[2:0]]))
        begin
            spos_next = spos_reg + PLEN_W'(1);
        end
        pfx_next = pfx_reg;
        if (cnt_reg < CNT_W'(plen) && word_byte != pat[cnt_reg[2:0]])
        begin
            pfx_next = 1'b0;
        end
        cpos_next = cpos_reg;
        clev_next = clev_reg;
        chalf_next = chalf_reg;
        if (cpos_reg < plen)
        begin
            if (fb == fold(pat[cpos_reg[2:0]]))
            begin
                if (clev_reg == 2'd1 || clev_reg == 2'd2)
                begin
                    chalf_next = chalf_reg + 5'd3;
                end
                else if (clev_reg == 2'd3)
                begin
                    chalf_next = chalf_reg + 5'd2;
                end
                if (clev_reg < 2'd3)
                begin
                    clev_next = clev_reg + 2'd1;
                end
                cpos_next = cpos_reg + PLEN_W'(1);
            end
            else
            begin
                clev_next = 2'd0;
            end
        end
        cnt_next = cnt_reg;
        if (cnt_reg <= MAXW)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        ovf_next = ovf_reg || (cnt_next > MAXW);

        acnt = bcnt_next;
        len16 = 16'(cnt_next);
        best = '0;
        if (len16 >= 16'd3 && acnt >= 2'd2 && !bfail_next && spos_next == plen)
        begin
            best = {plen, 1'b0};
        end
        if (plen > PLEN_W'(3) && pfx_next && len16 >= 16'(plen) && {plen, 1'b0} > best)
        begin
            best = {plen, 1'b0};
        end
        if (len16 >= 16'd8 && plen >= PLEN_W'(4) && cpos_next == plen && chalf_next > best)
        begin
            best = chalf_next;
        end
        sd_next.zero = ovf_next || (tail_mode && word_byte != CH_UNDER);
        sd_next.overlong = ovf_next;
        sd_next.best = best;
        sd_next.dbl = tail_mode;
        sd_next.len = len16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            prev_reg <= '0;
            skip_reg <= 1'b0;
            bcnt_reg <= '0;
            bpos_reg <= '0;
            bfail_reg <= 1'b0;
            spos_reg <= '0;
            pfx_reg <= 1'b1;
            cpos_reg <= '0;
            clev_reg <= '0;
            chalf_reg <= '0;
            ovf_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            // hold the summary until the queue takes it
            sv_reg <= (acc && word_end) || (sv_reg && !sum_ready);
            if (acc)
            begin
                if (word_end)
                begin
                    cnt_reg <= '0;
                    prev_reg <= '0;
                    skip_reg <= 1'b0;
                    bcnt_reg <= '0;
                    bpos_reg <= '0;
                    bfail_reg <= 1'b0;
                    spos_reg <= '0;
                    pfx_reg <= 1'b1;
                    cpos_reg <= '0;
                    clev_reg <= '0;
                    chalf_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_next;
                    prev_reg <= word_byte;
                    skip_reg <= skip_next;
                    bcnt_reg <= bcnt_next;
                    bpos_reg <= bpos_next;
                    bfail_reg <= bfail_next;
                    spos_reg <= spos_next;
                    pfx_reg <= pfx_next;
                    cpos_reg <= cpos_next;
                    clev_reg <= clev_next;
                    chalf_reg <= chalf_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && word_end)
        begin
            sd_reg <= sd_next;
        end
    end
endmodule

[design/fwms_queue.sv]
// Two-entry queue between the front and the back parts.
// Depends on fwms_pkg.
module fwms_queue
    import fwms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  summ_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output summ_t rd_data
);
    summ_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end
endmodule

[design/fwms_back.sv]
// Back part: restoring divider that turns a summary into the Q2.14 score.
// Depends on fwms_pkg.
module fwms_back
    import fwms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sum_valid,
    output logic                sum_ready,
    input  summ_t               sum_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SCORE_W-1:0]  out_score,
    output logic                out_overlong
);
    // numerator best*16384*(dbl?2:1), divisor 2*len; quotient fits 16 bits
    localparam int unsigned NUM_W = 21;
    localparam int unsigned DEN_W = 17;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t             st_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W:0]     rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [4:0]         step_reg;
    logic               ovl_reg;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     shifted;

    assign sum_ready = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_OUT);
    assign out_score = num_reg[SCORE_W-1:0];
    assign out_overlong = ovl_reg;
    assign shifted = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign trial = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            step_reg <= '0;
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    if (sum_valid)
                    begin
                        st_reg <= sum_data.zero ? ST_OUT : ST_DIV;
                        step_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(NUM_W - 1))
                    begin
                        st_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && sum_valid)
        begin
            num_reg <= sum_data.zero ? '0 :
                (sum_data.dbl ? {1'b0, sum_data.best, 15'd0}
                              : {2'b0, sum_data.best, 14'd0});
            rem_reg <= '0;
            den_reg <= {sum_data.len, 1'b0};
            ovl_reg <= sum_data.overlong;
        end
        else if (st_reg == ST_DIV)
        begin
            if (!trial[DEN_W])
            begin
                rem_reg <= trial;
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
        end
    end
endmodule

[design/fuzzy_word_match_scorer_top.sv]
// channel    | dir | payload
// s_axis     | in  | tdata[7:0] word_byte, tlast word_end
// m_axis     | out | tdata[15:0] score, tuser overlong
// cfg        | in  | cfg_we, cfg_addr, cfg_wdata (64 bits)
// One byte per cycle enters the front while it is not stalled; each word's result
// comes from the back divider (one quotient bit per cycle), buffered by a 2-entry queue.
// Reset clears all control state; pattern registers reset to zero.
// The front stalls only when its summary register and the queue are full.
// Top level of the fuzzy word match scorer; uses fwms_pkg and submodules.
module fuzzy_word_match_scorer_top
    import fwms_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = 8,
    parameter int unsigned MAX_WORD_LEN = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] word_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] score
    output logic        m_axis_tuser,   // [0] overlong
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);
    localparam int unsigned CNT_W = $clog2(MAX_WORD_LEN + 2);

    logic [63:0]       pat_reg;
    logic [PLEN_W-1:0] plen_reg;
    logic              term_reg;
    logic              f_valid, f_ready, b_valid, b_ready;
    summ_t             f_data, b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            plen_reg <= '0;
            term_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PATTERN:  pat_reg <= cfg_wdata;
                REG_LENGTH:   plen_reg <= cfg_wdata[PLEN_W-1:0];
                REG_TERMINUS: term_reg <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    fwms_front #(
        .MAX_PATTERN(MAX_PATTERN),
        .MAX_WORD_LEN(MAX_WORD_LEN),
        .CNT_W(CNT_W)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .pattern_bytes(pat_reg), .pattern_length(plen_reg), .tail_mode(term_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .word_byte(s_axis_tdata), .word_end(s_axis_tlast),
        .sum_valid(f_valid), .sum_ready(f_ready), .sum_data(f_data)
    );

    fwms_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    fwms_back u_back (
        .clk(clk), .rst_n(rst_n),
        .sum_valid(b_valid), .sum_ready(b_ready), .sum_data(b_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_score(m_axis_tdata), .out_overlong(m_axis_tuser)
    );
endmodule

[design/fwms_checker.sv]
// Port-level checker for the match scorer, bound to the top level.
// Depends on fuzzy_word_match_scorer_top_defines.svh.
`include "fuzzy_word_match_scorer_top_defines.svh"
module fwms_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // an overlong word always scores zero
    `FWMS_ASSERT(a_ovl_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0, "overlong score not zero")
    // score never exceeds 2.0
    `FWMS_ASSERT(a_max, m_axis_tvalid |-> m_axis_tdata <= 16'd32768, "score above 2.0")
    // held result keeps its value
    `FWMS_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    // no result during reset
    `FWMS_ASSERT_ALWAYS(a_rst, !rst_n |-> !m_axis_tvalid, "result during reset")
endmodule

bind fuzzy_word_match_scorer_top fwms_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

[tb/sv/tb_fuzzy_word_match_scorer_top.sv]
// Self-checking bench for the fuzzy word match scorer: streams words, predicts scores.
// Depends on fwms_pkg and fuzzy_word_match_scorer_top.
module tb_fuzzy_word_match_scorer_top;
    import fwms_pkg::*;

    localparam int unsigned WORD_LIMIT = 255;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] score;
        logic        overlong;
    } score_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [63:0] cfg_wdata;

    byte_item_t  pending_bytes[$];
    score_item_t expected_scores[$];
    int          error_count;
    bit          idle_free;

    // predictor copy of configuration and per-word state
    logic [63:0] m_pat;
    logic [3:0]  m_plen_raw;
    logic        m_term;
    int unsigned w_count, w_prev, w_skip, w_bcnt, w_bpos, w_bfail;
    int unsigned w_sub, w_prefix, w_cpos, w_clev, w_chalves, w_over;

    fuzzy_word_match_scorer_top DUT (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [7:0] low_case(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    function automatic bit upper_ch(input int unsigned b);
        return b >= 32'h41 && b <= 32'h5A;
    endfunction

    function automatic logic [7:0] pat_at(input int unsigned k);
        return m_pat[k*8 +: 8];
    endfunction

    task automatic clear_word_state();
        w_count = 0; w_prev = 0; w_skip = 0; w_bcnt = 0; w_bpos = 0; w_bfail = 0;
        w_sub = 0; w_prefix = 1; w_cpos = 0; w_clev = 0; w_chalves = 0; w_over = 0;
    endtask

    // advance the word state by one byte; queue an expected score at word end
    task automatic predict_byte(input logic [7:0] b, input logic last);
        int unsigned plen;
        int unsigned p;
        bit push;
        longint unsigned best, len, sc;
        score_item_t exp_item;
        plen = (m_plen_raw > PAT_BYTES) ? PAT_BYTES : m_plen_raw;
        push = 0;
        if (w_count == 0)
            push = 1;
        else if (w_count >= 2)
        begin
            if (w_skip)
                w_skip = 0;
            else if (w_prev == CH_UNDER || w_prev == CH_DASH
                     || (!upper_ch(w_prev) && upper_ch(b)))
            begin
                push = 1;
                w_skip = 1;
            end
        end
        if (push)
        begin
            if (w_bcnt < 2)
                w_bcnt++;
            if (!w_bfail)
            begin
                p = w_bpos;
                while (p < plen && low_case(pat_at(p)) != low_case(b))
                    p++;
                if (p < plen)
                    w_bpos = p + 1;
                else
                    w_bfail = 1;
            end
        end
        if (w_sub < plen && low_case(b) == low_case(pat_at(w_sub)))
            w_sub++;
        if (w_count < plen && b != pat_at(w_count))
            w_prefix = 0;
        if (w_cpos < plen)
        begin
            if (low_case(b) == low_case(pat_at(w_cpos)))
            begin
                if (w_clev == 1 || w_clev == 2)
                    w_chalves += 3;
                else if (w_clev == 3)
                    w_chalves += 2;
                if (w_clev < 3)
                    w_clev++;
                w_cpos++;
            end
            else
                w_clev = 0;
        end
        w_prev = b;
        if (w_count <= WORD_LIMIT)
            w_count++;
        if (w_count > WORD_LIMIT)
            w_over = 1;
        if (last)
        begin
            len = w_count;
            best = 0;
            sc = 0;
            if (!w_over && !(m_term && b != CH_UNDER))
            begin
                if (len >= 3 && w_bcnt >= 2 && !w_bfail && w_sub == plen)
                    best = 2 * plen;
                if (plen > 3 && w_prefix && len >= plen && 2 * plen > best)
                    best = 2 * plen;
                if (len >= 8 && plen >= 4 && w_cpos == plen && w_chalves > best)
                    best = w_chalves;
                sc = best * 16384 * (m_term ? 2 : 1) / (2 * len);
            end
            exp_item.score = sc[15:0];
            exp_item.overlong = w_over[0];
            expected_scores.insert(expected_scores.size(), exp_item);
            clear_word_state();
        end
    endtask

    // driver: feed the byte stream, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_bytes.size() > 0 && (idle_free || $urandom_range(99) >= 18))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_bytes[0].ch;
                s_axis_tlast <= pending_bytes[0].last;
                predict_byte(pending_bytes[0].ch, pending_bytes[0].last);
                void'(pending_bytes.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: random backpressure, compare each score transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $display("%0t: unexpected score %h overlong %b", $time,
                             m_axis_tdata, m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    if (m_axis_tdata !== expected_scores[0].score
                        || m_axis_tuser !== expected_scores[0].overlong)
                    begin
                        $display("%0t: expected score %h overlong %b, got %h %b", $time,
                                 expected_scores[0].score, expected_scores[0].overlong,
                                 m_axis_tdata, m_axis_tuser);
                        error_count++;
                    end
                    void'(expected_scores.pop_front());
                end
            end
            m_axis_tready <= idle_free || ($urandom_range(99) >= 18);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PATTERN: m_pat = val;
            REG_LENGTH: m_plen_raw = val[3:0];
            default: m_term = val[0];
        endcase
    endtask

    task automatic queue_word(input logic [7:0] w[$]);
        byte_item_t item;
        foreach (w[i])
        begin
            item.ch = w[i];
            item.last = (i == w.size() - 1);
            pending_bytes.insert(pending_bytes.size(), item);
        end
    endtask

    task automatic queue_text(input string s);
        logic [7:0] w[$];
        for (int i = 0; i < s.len(); i++)
            w.insert(w.size(), s[i]);
        queue_word(w);
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || expected_scores.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_char(input logic [63:0] pat, input int unsigned pl);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45 && pl > 0)
        begin
            logic [7:0] c;
            c = pat[$urandom_range(pl - 1)*8 +: 8];
            return ($urandom_range(1) && c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
        end
        if (r < 60)
            return $urandom_range(1) ? CH_UNDER : CH_DASH;
        if (r < 85)
            return 8'(8'h61 + $urandom_range(25));
        if (r < 92)
            return 8'(8'h41 + $urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    // word built from the pattern with random insertions, or pure noise
    task automatic queue_random_word(input logic [63:0] pat, input int unsigned pl,
                                     input bit ends_under);
        logic [7:0] w[$];
        int unsigned n;
        n = $urandom_range(1, 14);
        if ($urandom_range(99) < 60 && pl > 0)
        begin
            for (int k = 0; k < pl; k++)
            begin
                if ($urandom_range(3) == 0)
                    w.insert(w.size(), rand_char(pat, pl));
                w.insert(w.size(), (k == 0 || $urandom_range(2) == 0) ? pat[k*8 +: 8]
                                   : (pat[k*8 +: 8] ^ 8'h20));
            end
            if ($urandom_range(1))
                w.insert(w.size(), rand_char(pat, pl));
        end
        else
            for (int k = 0; k < n; k++)
                w.insert(w.size(), rand_char(pat, pl));
        if (ends_under && $urandom_range(3) != 0)
            w.insert(w.size(), CH_UNDER);
        queue_word(w);
    endtask

    initial
    begin
        logic [63:0] pat;
        int unsigned pl;
        int unsigned per_phase;
        logic [7:0] big[$];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_PATTERN;
        cfg_wdata = '0;
        error_count = 0;
        idle_free = 0;
        m_pat = '0;
        m_plen_raw = '0;
        m_term = 1'b0;
        clear_word_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern from reset
        queue_text("Hello_World");
        drain();
        write_reg(REG_PATTERN, 64'h0000_0000_7872_6f66);   // "forx"
        write_reg(REG_LENGTH, 64'd4);
        queue_text("forxyzab");
        queue_text("FoRx_Yield");
        queue_text("f-o-r-x_abc");
        queue_text("abforxzz");
        queue_text("fo");
        queue_text("fooBarXy");
        drain();
        write_reg(REG_TERMINUS, 64'd1);
        queue_text("forxab__");
        queue_text("forxabcd");
        queue_text("_");
        drain();
        write_reg(REG_TERMINUS, 64'd0);
        write_reg(REG_PATTERN, 64'hFFC1_8041_7A5F_2D61);
        write_reg(REG_LENGTH, 64'd15);                     // clamps to eight
        big = {8'h61, 8'h2D, 8'h5F, 8'h7A, 8'h41, 8'h80, 8'hC1, 8'hFF, 8'h00};
        queue_word(big);
        big.delete();
        // one byte past the length limit
        for (int i = 0; i < 256; i++)
            big.insert(big.size(), 8'h61);
        queue_word(big);
        queue_text("x");
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            pat = {$urandom, $urandom};
            for (int k = 0; k < 8; k++)
                if ($urandom_range(3) != 0)
                    pat[k*8 +: 8] = 8'(8'h61 + $urandom_range(25));
            pl = (ph == 0) ? 8 : (ph == 1) ? 0 : $urandom_range(15);
            write_reg(REG_PATTERN, pat);
            write_reg(REG_LENGTH, 64'(pl));
            write_reg(REG_TERMINUS, 64'(ph % 3 == 2));
            if (pl > 8)
                pl = 8;
            idle_free = (ph == 4);
            per_phase = 0;
            while (per_phase < 24)
            begin
                queue_random_word(pat, pl, ph % 3 == 2);
                per_phase += 8;
            end
            drain();
        end

        if (error_count == 0)
            $display("tb_fuzzy_word_match_scorer_top: PASS");
        else
            $display("tb_fuzzy_word_match_scorer_top: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_fuzzy_word_match_scorer_top: FAIL");
        $finish;
    end
endmodule
